// ----- rtl/min_stack_encoded_macros.svh -----
// assertion macros shared by the min stack rtl
// expects clk and arst_n in the scope of every use
`ifndef MIN_STACK_ENCODED_MACROS_SVH
`define MIN_STACK_ENCODED_MACROS_SVH

`ifndef SYNTHESIS
`define MSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MSE_ASSERT_IMP(lbl, ante, cons)
`define MSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/msenc_pkg.sv -----
// shared types, sizes and codes of the min stack
// no dependencies
package msenc_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int WORD_WIDTH = DATA_WIDTH + 2;
	localparam int ADDR_WIDTH = $clog2(DEPTH);
	localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [WORD_WIDTH-1:0] word_t;
	typedef logic [CNT_WIDTH-1:0]         cnt_t;
	typedef logic [ADDR_WIDTH-1:0]        addr_t;

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam data_t NEG_ONE  = '1;
	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	function automatic word_t sext(input data_t d);
		return {{(WORD_WIDTH-DATA_WIDTH){d[DATA_WIDTH-1]}}, d};
	endfunction

endpackage

// ----- rtl/msenc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module msenc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/min_stack_encoded.sv -----
// min stack top level: lifo of signed words that reports its minimum with every result
// depends on msenc_pkg, msenc_ram and min_stack_encoded_macros.svh
//
// Each beat on the input is a push, pop or peek; each gives exactly one result beat
// carrying the top or popped value, the minimum, an empty flag and a status. Push,
// peek, any access to an empty stack and a pop that empties the stack need no fetch;
// a pop that leaves entries behind goes through the fetch state, because the new top
// word is read from the stack ram into the cached top register before the next beat
// is taken. A result that waits on the output holds off the input.
// A smaller push than the current minimum stores the encoded word 2*value-minimum, so
// the ram words are two bits wider than the data. No clearing pass is needed after reset.
`include "min_stack_encoded_macros.svh"

module min_stack_encoded (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  msenc_pkg::data_t         value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output msenc_pkg::data_t         result_value,
	output msenc_pkg::data_t         minimum,
	output logic                     is_empty,
	output logic [1:0]               status
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_FETCH = 2'b10
	} state_t;

	state_t               state_q;
	msenc_pkg::cnt_t      count_q;
	msenc_pkg::data_t     min_q;
	msenc_pkg::word_t     top_q;

	logic                 out_valid_q;
	msenc_pkg::data_t     res_q;
	msenc_pkg::data_t     min_out_q;
	logic                 empty_q;
	logic [1:0]           status_q;

	logic                 acc;
	msenc_pkg::word_t     v_w;
	msenc_pkg::word_t     min_w;
	msenc_pkg::word_t     enc_w;
	msenc_pkg::word_t     restore_w;
	msenc_pkg::data_t     top_dec;
	msenc_pkg::cnt_t      cnt_m2;

	msenc_pkg::cnt_t      n_count;
	msenc_pkg::data_t     n_min;
	msenc_pkg::word_t     n_top;
	msenc_pkg::data_t     res_d;
	logic [1:0]           st_d;
	logic                 we;
	logic                 re;
	msenc_pkg::word_t     rd_data;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);

	assign v_w       = msenc_pkg::sext(value);
	assign min_w     = msenc_pkg::sext(min_q);
	assign enc_w     = (v_w <<< 1) - min_w;
	assign restore_w = (min_w <<< 1) - top_q;
	// an encoded top word sits below the minimum, the real top is then the minimum
	assign top_dec   = (top_q < min_w) ? min_q : top_q[msenc_pkg::DATA_WIDTH-1:0];
	assign cnt_m2    = count_q - msenc_pkg::cnt_t'(2);

	always_comb begin
		n_count = count_q;
		n_min   = min_q;
		n_top   = top_q;
		res_d   = msenc_pkg::NEG_ONE;
		st_d    = msenc_pkg::ST_OK;
		we      = 1'b0;
		re      = 1'b0;
		case (mode)
			msenc_pkg::MODE_PUSH: begin
				if (count_q == '0) begin
					n_count = msenc_pkg::cnt_t'(1);
					n_min   = value;
					n_top   = v_w;
					we      = 1'b1;
					res_d   = value;
				end else if (count_q == msenc_pkg::cnt_t'(msenc_pkg::DEPTH)) begin
					st_d  = msenc_pkg::ST_FULL;
					res_d = top_dec;
				end else begin
					we      = 1'b1;
					n_count = count_q + msenc_pkg::cnt_t'(1);
					res_d   = value;
					if (v_w < min_w) begin
						n_top = enc_w;
						n_min = value;
					end else begin
						n_top = v_w;
					end
				end
			end
			msenc_pkg::MODE_POP: begin
				if (count_q == '0) begin
					st_d = msenc_pkg::ST_EMPTY;
				end else begin
					res_d   = top_dec;
					n_count = count_q - msenc_pkg::cnt_t'(1);
					re      = (count_q > msenc_pkg::cnt_t'(1));
					if (top_q < min_w) begin
						n_min = restore_w[msenc_pkg::DATA_WIDTH-1:0];
					end
				end
			end
			default: begin
				// peek, and the unused code behaves the same
				if (count_q == '0) begin
					st_d = msenc_pkg::ST_EMPTY;
				end else begin
					res_d = top_dec;
				end
			end
		endcase
	end

	msenc_ram #(
		.WIDTH (msenc_pkg::WORD_WIDTH),
		.DEPTH (msenc_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (acc && we),
		.wr_addr (count_q[msenc_pkg::ADDR_WIDTH-1:0]),
		.wr_data (n_top),
		.rd_en   (acc && re),
		.rd_addr (cnt_m2[msenc_pkg::ADDR_WIDTH-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			min_q       <= msenc_pkg::DATA_MAX;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						count_q <= n_count;
						min_q   <= n_min;
						if (re) begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// cached top word and the result beat need no reset
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			top_q <= rd_data;
		end else if (acc) begin
			top_q <= n_top;
		end
		if (acc) begin
			res_q     <= res_d;
			min_out_q <= (n_count == '0) ? msenc_pkg::NEG_ONE : n_min;
			empty_q   <= (n_count == '0);
			status_q  <= st_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q;
	assign minimum      = min_out_q;
	assign is_empty     = empty_q;
	assign status       = status_q;

	`MSE_ASSERT_IMP(a_count_range, 1'b1, count_q <= msenc_pkg::cnt_t'(msenc_pkg::DEPTH))
	`MSE_ASSERT_IMP(a_no_take_in_fetch, state_q == S_FETCH, in_stall)
	`MSE_ASSERT_NXT(a_deep_pop_fetches,
		acc && mode == msenc_pkg::MODE_POP && count_q > msenc_pkg::cnt_t'(1),
		state_q == S_FETCH)
	`MSE_ASSERT_IMP(a_empty_status,
		out_valid_q && status_q == msenc_pkg::ST_EMPTY, empty_q)
	`MSE_ASSERT_IMP(a_top_not_below_min,
		state_q == S_IDLE && count_q != '0, top_dec >= min_q)

endmodule
